FILE: hdl/idb_pkg.sv
// Shared types and constants for the indexed deque buffer.
// No dependencies; the files that use it refer to this package by scoped names.
package idb_pkg;

  localparam int DEPTH_DEF     = 1024;
  localparam int WORD_BITS_DEF = 32;

  localparam int MODE_W     = 3;
  localparam int DATA_W     = 32;
  localparam int POS_W      = 10;
  localparam int STATUS_W   = 2;
  localparam int OCC_W      = 11;
  // Widest slot index over the supported depth range (up to 65536 entries).
  localparam int SLOT_MAX_W = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_BACK  = 3'd0,
    MODE_PUSH_FRONT = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_READ       = 3'd4,
    MODE_WRITE      = 3'd5
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // One classified request on its way from the front end to the store.
  typedef struct packed {
    logic                  wr;
    logic                  rd;
    logic [SLOT_MAX_W-1:0] slot;
    logic [DATA_W-1:0]     word;
    status_t               status;
    logic [OCC_W-1:0]      occ;
  } op_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    status_t           status;
    logic [OCC_W-1:0]  occ;
  } res_t;

endpackage

FILE: hdl/idb_if.sv
// Valid/ready channel interfaces for request and result transfers.
// Depends on idb_pkg for field widths.
interface idb_in_if;
  logic                         valid;
  logic                         ready;
  logic [idb_pkg::MODE_W-1:0]   mode;
  logic [idb_pkg::DATA_W-1:0]   data_in;
  logic [idb_pkg::POS_W-1:0]    position;

  modport source (output valid, output mode, output data_in, output position, input ready);
  modport sink   (input valid, input mode, input data_in, input position, output ready);
endinterface

interface idb_out_if;
  logic                         valid;
  logic                         ready;
  logic [idb_pkg::DATA_W-1:0]   data_out;
  logic [idb_pkg::STATUS_W-1:0] status;
  logic [idb_pkg::OCC_W-1:0]    occupancy;

  modport source (output valid, output data_out, output status, output occupancy, input ready);
  modport sink   (input valid, input data_out, input status, input occupancy, output ready);
endinterface

FILE: hdl/idb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; contents are undefined until written.
module idb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

FILE: hdl/idb_fifo.sv
// Small register FIFO of a generic item type, power-of-two entries.
// No package dependency; used for the request queue and the result queue.
module idb_fifo #(
  parameter type ITEM_T = logic,
  parameter int  ADDR_W = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  ITEM_T         push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output ITEM_T         pop_data,
  output logic [ADDR_W:0] count
);

  localparam int ENTRIES = 2 ** ADDR_W;

  ITEM_T             slots_r [ENTRIES];
  logic [ADDR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [ADDR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [ADDR_W:0]   count_r, count_nxt;
  logic              push, pop;

  always_comb begin
    push_ready = (count_r != (ADDR_W+1)'(ENTRIES));
    pop_valid  = (count_r != '0);
    pop_data   = slots_r[rd_ptr_r];
    count      = count_r;
    push       = push_valid && push_ready;
    pop        = pop_valid && pop_ready;
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (ADDR_W+1)'(push) - (ADDR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: hdl/idb_front.sv
// Front end: accepts requests, checks them against the count, updates the
// front pointer and count, and emits one classified store operation. Uses idb_pkg, idb_if.
module idb_front #(
  parameter int DEPTH = idb_pkg::DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  idb_in_if.sink         in_chan,
  output idb_pkg::op_t   op,
  output logic           op_valid,
  input  logic           op_ready
);

  localparam int PW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > idb_pkg::POS_W) ? CW : idb_pkg::POS_W;

  logic [PW-1:0] front_r, front_nxt, front_new;
  logic [CW-1:0] count_r, count_nxt, count_new;
  logic          take, is_full, is_empty, out_of_range;
  logic [PW-1:0] back_slot, last_slot, pos_slot, dec_front, inc_front;

  // Ring addition; both operands are below DEPTH, so one subtract wraps it.
  function automatic logic [PW-1:0] wrap_add(logic [PW-1:0] base, logic [PW-1:0] ofs);
    logic [PW:0] sum;
    sum = {1'b0, base} + {1'b0, ofs};
    if (sum >= (PW+1)'(DEPTH)) begin
      sum = sum - (PW+1)'(DEPTH);
    end
    return sum[PW-1:0];
  endfunction

  always_comb begin
    take         = in_chan.valid && op_ready;
    in_chan.ready = op_ready;
    op_valid     = in_chan.valid;

    is_full      = (count_r == CW'(DEPTH));
    is_empty     = (count_r == '0);
    out_of_range = (CMPW'(in_chan.position) >= CMPW'(count_r));

    back_slot = wrap_add(front_r, PW'(count_r));
    last_slot = wrap_add(front_r, PW'(count_r - CW'(1)));
    pos_slot  = wrap_add(front_r, PW'(in_chan.position));
    dec_front = (front_r == '0) ? PW'(DEPTH - 1) : front_r - PW'(1);
    inc_front = (front_r == PW'(DEPTH - 1)) ? '0 : front_r + PW'(1);

    front_new = front_r;
    count_new = count_r;
    op.wr     = 1'b0;
    op.rd     = 1'b0;
    op.slot   = '0;
    op.word   = in_chan.data_in;
    op.status = idb_pkg::ST_OK;

    case (idb_pkg::mode_t'(in_chan.mode))
      idb_pkg::MODE_PUSH_BACK: begin
        if (is_full) begin
          op.status = idb_pkg::ST_FULL;
        end else begin
          op.wr     = 1'b1;
          op.slot   = idb_pkg::SLOT_MAX_W'(back_slot);
          count_new = count_r + CW'(1);
        end
      end
      idb_pkg::MODE_PUSH_FRONT: begin
        if (is_full) begin
          op.status = idb_pkg::ST_FULL;
        end else begin
          op.wr     = 1'b1;
          op.slot   = idb_pkg::SLOT_MAX_W'(dec_front);
          front_new = dec_front;
          count_new = count_r + CW'(1);
        end
      end
      idb_pkg::MODE_POP_FRONT: begin
        if (is_empty) begin
          op.status = idb_pkg::ST_EMPTY;
        end else begin
          op.rd     = 1'b1;
          op.slot   = idb_pkg::SLOT_MAX_W'(front_r);
          front_new = inc_front;
          count_new = count_r - CW'(1);
        end
      end
      idb_pkg::MODE_POP_BACK: begin
        if (is_empty) begin
          op.status = idb_pkg::ST_EMPTY;
        end else begin
          op.rd     = 1'b1;
          op.slot   = idb_pkg::SLOT_MAX_W'(last_slot);
          count_new = count_r - CW'(1);
        end
      end
      idb_pkg::MODE_READ: begin
        if (out_of_range) begin
          op.status = idb_pkg::ST_RANGE;
        end else begin
          op.rd   = 1'b1;
          op.slot = idb_pkg::SLOT_MAX_W'(pos_slot);
        end
      end
      idb_pkg::MODE_WRITE: begin
        if (out_of_range) begin
          op.status = idb_pkg::ST_RANGE;
        end else begin
          op.wr   = 1'b1;
          op.slot = idb_pkg::SLOT_MAX_W'(pos_slot);
        end
      end
      default: begin
        // Unused modes leave everything as it is and report ok.
      end
    endcase

    op.occ    = idb_pkg::OCC_W'(count_new);
    front_nxt = take ? front_new : front_r;
    count_nxt = take ? count_new : count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

FILE: hdl/idb_back.sv
// Back end: carries out queued store operations on the ring RAM and queues
// the results for the output channel. Uses idb_pkg, idb_if, idb_ram, idb_fifo.
module idb_back #(
  parameter int DEPTH  = idb_pkg::DEPTH_DEF,
  parameter int STORE_W = idb_pkg::WORD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  idb_pkg::op_t  op,
  input  logic          op_valid,
  output logic          op_ready,
  idb_out_if.source     out_chan
);

  localparam int PW = $clog2(DEPTH);

  logic                 issue, res_pop;
  logic [1:0]           res_count;
  logic                 inflight_r;
  logic                 rd_r;
  idb_pkg::status_t     status_r;
  logic [idb_pkg::OCC_W-1:0] occ_r;
  logic [STORE_W-1:0]   rd_data;
  idb_pkg::res_t        res_in, res_out;

  // A new operation goes only when the result queue is sure to have room
  // for it, counting the one still in the RAM read.
  always_comb begin
    res_pop  = out_chan.valid && out_chan.ready;
    issue    = op_valid &&
               ((3'({1'b0, res_count}) + 3'(inflight_r)) < (3'd2 + 3'(res_pop)));
    op_ready = issue;

    res_in.data   = rd_r ? idb_pkg::DATA_W'(rd_data) : '0;
    res_in.status = status_r;
    res_in.occ    = occ_r;

    out_chan.data_out  = res_out.data;
    out_chan.status    = res_out.status;
    out_chan.occupancy = res_out.occ;
  end

  idb_ram #(
    .WIDTH (STORE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (issue && op.wr),
    .wr_addr (op.slot[PW-1:0]),
    .wr_data (op.word[STORE_W-1:0]),
    .rd_en   (issue && op.rd),
    .rd_addr (op.slot[PW-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= 1'b0;
    end else begin
      inflight_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_r     <= op.rd;
      status_r <= op.status;
      occ_r    <= op.occ;
    end
  end

  idb_fifo #(
    .ITEM_T (idb_pkg::res_t),
    .ADDR_W (1)
  ) u_res_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (inflight_r),
    .push_ready (),
    .push_data  (res_in),
    .pop_valid  (out_chan.valid),
    .pop_ready  (out_chan.ready),
    .pop_data   (res_out),
    .count      (res_count)
  );

endmodule

FILE: hdl/indexed_deque_buffer_unit.sv
// Indexed deque buffer: ring-store double-ended queue with indexed read and write.
// A request passes the request queue, the RAM read and then the result queue.
// Throughput: one request per cycle while out_chan is ready, set by the single RAM ports.
// Reset (synchronous, active low) clears front pointer, count and queues; the store
// contents stay undefined and need no clearing pass.
// Uses idb_pkg, idb_if, idb_fifo, idb_front, idb_back.
module indexed_deque_buffer_unit #(
  parameter int DEPTH     = idb_pkg::DEPTH_DEF,
  parameter int WORD_BITS = idb_pkg::WORD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  idb_in_if.sink     in_chan,
  idb_out_if.source  out_chan
);

  // Words arrive on a fixed 32-bit field, so no more than that is ever stored.
  localparam int STORE_W = (WORD_BITS < idb_pkg::DATA_W) ? WORD_BITS : idb_pkg::DATA_W;
  localparam int OW      = idb_pkg::OCC_W;
  localparam logic [OW-1:0] FULL_OCC = OW'(DEPTH);

  idb_pkg::op_t op_in, op_out;
  logic         op_in_valid, op_in_ready;
  logic         op_out_valid, op_out_ready;

  idb_front #(
    .DEPTH (DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .op       (op_in),
    .op_valid (op_in_valid),
    .op_ready (op_in_ready)
  );

  idb_fifo #(
    .ITEM_T (idb_pkg::op_t),
    .ADDR_W (1)
  ) u_op_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (op_in_valid),
    .push_ready (op_in_ready),
    .push_data  (op_in),
    .pop_valid  (op_out_valid),
    .pop_ready  (op_out_ready),
    .pop_data   (op_out),
    .count      ()
  );

  idb_back #(
    .DEPTH   (DEPTH),
    .STORE_W (STORE_W)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (op_out),
    .op_valid (op_out_valid),
    .op_ready (op_out_ready),
    .out_chan (out_chan)
  );

`ifndef SYNTHESIS
  // A push refused as full must report a completely filled ring.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && op_in.status == idb_pkg::ST_FULL)
      |-> (op_in.occ == FULL_OCC))
    else $error("full status with occupancy below depth");

  // A pop refused as empty must report zero occupancy and touch nothing.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && op_in.status == idb_pkg::ST_EMPTY)
      |-> (op_in.occ == '0 && !op_in.wr && !op_in.rd))
    else $error("empty status with nonzero occupancy or store access");

  // Failing requests deliver a zero word.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.ready && out_chan.status != idb_pkg::ST_OK)
      |-> (out_chan.data_out == '0))
    else $error("nonzero data on a failing result");
`endif

endmodule
